// ----- hdl/uv_barycentric_normal_baker_core_macros.svh -----
// assertion macros for the uv barycentric normal baker
`ifndef UV_BARYCENTRIC_NORMAL_BAKER_CORE_MACROS_SVH
`define UV_BARYCENTRIC_NORMAL_BAKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define UVBNB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvbnb assertion failed");
`define UVBNB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvbnb assertion failed");
`else
`define UVBNB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UVBNB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/uvbnb_pkg.sv -----
// shared constants for the uv barycentric normal baker
`default_nettype none
package uvbnb_pkg;
    localparam int MAX_TRIS   = 256;
    localparam int TRI_IDX_W  = $clog2(MAX_TRIS);
    localparam int TRI_CNT_W  = $clog2(MAX_TRIS + 1);

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_BAKE   = 2'd2;

    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;
    localparam logic [12:0] TEX_SIZE_RESET = 13'd256;

    localparam logic [31:0] NEAR_ZERO_SQ = 32'd268;
    localparam logic [15:0] DEF_RED   = 16'd32768;
    localparam logic [15:0] DEF_GREEN = 16'd32768;
    localparam logic [15:0] DEF_BLUE  = 16'd65535;

    // shared divider geometry
    localparam int DIV_NUM_W = 52;
    localparam int DIV_DEN_W = 35;
    localparam int DIV_Q_W   = 17;
endpackage
`default_nettype wire

// ----- hdl/uvbnb_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module uvbnb_div import uvbnb_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [DIV_NUM_W-1:0]  i_num,
    input  wire [DIV_DEN_W-1:0]  i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);
    localparam int SH_W = DIV_DEN_W + DIV_Q_W - 1;
    localparam int K_W  = $clog2(DIV_Q_W);

    logic [DIV_NUM_W-1:0] r_rem;
    logic [SH_W-1:0]      r_dsh;
    logic [K_W-1:0]       r_k;
    logic [DIV_Q_W-1:0]   r_quo;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_NUM_W:0]   w_diff;

    // quotient must fit: num < den << DIV_Q_W
    assign w_diff = {1'b0, r_rem} - {{(DIV_NUM_W + 1 - SH_W){1'b0}}, r_dsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rem  <= i_num;
                r_dsh  <= {i_den, {(DIV_Q_W-1){1'b0}}};
                r_k    <= K_W'(DIV_Q_W - 1);
                r_quo  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[DIV_NUM_W]) begin
                    r_rem <= w_diff[DIV_NUM_W-1:0];
                end
                r_quo <= {r_quo[DIV_Q_W-2:0], ~w_diff[DIV_NUM_W]};
                r_dsh <= r_dsh >> 1;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ----- hdl/uv_barycentric_normal_baker_core.sv -----
// top level of the uv barycentric normal baker
// Clear and append requests go straight to the result state. A bake request first
// divides the texel coordinates by the texture size on the shared divider (a texel
// past the edge saturates), then streams the triangle table from memory one row per
// cycle through a three-stage test pipeline. On a hit it reads the hit row's normals,
// forms each channel with three multiply-accumulates and a rounded divide, sums the
// squares and, unless the sum is near zero, runs a 31-step square root and three
// encode divides. One request is in work at a time; the next is taken while a
// finished result waits at the output. Triangle storage has no reset; only rows
// below the triangle count are ever read.
`default_nettype none
`include "uv_barycentric_normal_baker_core_macros.svh"
module uv_barycentric_normal_baker_core import uvbnb_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire [12:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [1:0]   i_mode,
    input  wire [31:0]  i_uv_a,
    input  wire [31:0]  i_uv_b,
    input  wire [31:0]  i_uv_c,
    input  wire [47:0]  i_norm_a,
    input  wire [47:0]  i_norm_b,
    input  wire [47:0]  i_norm_c,
    input  wire [11:0]  i_texel_x,
    input  wire [11:0]  i_texel_y,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_status,
    output logic        o_hit,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);
    typedef enum logic [4:0] {
        S_IDLE, S_U_START, S_U_WAIT, S_V_START, S_V_WAIT, S_WALK, S_NREAD,
        S_MUL, S_ACC, S_MDIV_START, S_MDIV_WAIT, S_SQMUL, S_SQACC, S_CHECK,
        S_SQRT, S_ENC_START, S_ENC_WAIT, S_RESULT
    } t_state;

    t_state r_state;

    logic [95:0]  r_uv_mem [MAX_TRIS];
    logic [143:0] r_nm_mem [MAX_TRIS];
    logic [95:0]  r_uv_rd;
    logic [143:0] r_nm_rd;

    logic [TRI_CNT_W-1:0] r_tri_count;
    logic [12:0] r_tex_w, r_tex_h;
    logic [11:0] r_tx, r_ty;
    logic [15:0] r_pu, r_pv;

    // walk pipeline
    logic [TRI_CNT_W-1:0] r_wi;
    logic                 r_v1, r_v2, r_v3;
    logic [TRI_IDX_W-1:0] r_i1, r_i2, r_i3, r_hit_idx;
    logic signed [16:0]   r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [33:0]   r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    logic [33:0]          r_d, r_u, r_v;
    logic [1:0]           r_c, r_k;
    logic signed [52:0]   r_prod, r_acc;
    logic [16:0]          r_m [3];
    logic [31:0]          r_s;
    logic [60:0]          r_sq_n, r_sq_r, r_sq_bit;
    logic [30:0]          r_len;

    logic        r_res_status, r_res_hit;
    logic [15:0] r_col [3];
    logic        r_out_valid, r_out_status, r_out_hit;
    logic [15:0] r_out_red, r_out_green, r_out_blue;

    logic w_accept, w_issue;
    logic [12:0] w_weff, w_heff;

    // divider hookup
    logic                 w_div_start, w_div_busy, w_div_done;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [DIV_Q_W-1:0]   w_div_quo;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_weff   = (r_tex_w == '0) ? 13'd1 : r_tex_w;
    assign w_heff   = (r_tex_h == '0) ? 13'd1 : r_tex_h;
    assign w_issue  = (r_state == S_WALK) && (r_wi < r_tri_count);

    // triangle test on stage 3
    logic signed [34:0] w_d, w_u, w_v, w_dn, w_un, w_vn;
    logic [35:0]        w_uv_sum;
    logic               w_pass;
    assign w_d  = 35'(r_p0) - 35'(r_p1);
    assign w_u  = 35'(r_p2) - 35'(r_p3);
    assign w_v  = 35'(r_p4) - 35'(r_p5);
    assign w_dn = w_d[34] ? -w_d : w_d;
    assign w_un = w_d[34] ? -w_u : w_u;
    assign w_vn = w_d[34] ? -w_v : w_v;
    assign w_uv_sum = {1'b0, w_un} + {1'b0, w_vn};
    assign w_pass = (w_d != '0) && !w_un[34] && !w_vn[34] && (w_uv_sum <= {1'b0, w_dn});

    // stage 1 differences
    logic signed [16:0] w_x0, w_y0, w_x1, w_y1, w_x2, w_y2;
    assign w_x0 = $signed({1'b0, r_uv_rd[63:48]}) - $signed({1'b0, r_uv_rd[95:80]});
    assign w_y0 = $signed({1'b0, r_uv_rd[47:32]}) - $signed({1'b0, r_uv_rd[79:64]});
    assign w_x1 = $signed({1'b0, r_uv_rd[31:16]}) - $signed({1'b0, r_uv_rd[95:80]});
    assign w_y1 = $signed({1'b0, r_uv_rd[15:0]})  - $signed({1'b0, r_uv_rd[79:64]});
    assign w_x2 = $signed({1'b0, r_pu}) - $signed({1'b0, r_uv_rd[95:80]});
    assign w_y2 = $signed({1'b0, r_pv}) - $signed({1'b0, r_uv_rd[79:64]});

    // shared multiplier operands
    logic [47:0]        w_nk;
    logic [15:0]        w_nval;
    logic [33:0]        w_wt;
    logic signed [16:0] w_ma;
    logic signed [35:0] w_mb;
    logic signed [52:0] w_prod;
    always_comb begin
        case (r_k)
            2'd0:    w_nk = r_nm_rd[143:96];
            2'd1:    w_nk = r_nm_rd[95:48];
            default: w_nk = r_nm_rd[47:0];
        endcase
        case (r_c)
            2'd0:    w_nval = w_nk[47:32];
            2'd1:    w_nval = w_nk[31:16];
            default: w_nval = w_nk[15:0];
        endcase
        case (r_k)
            2'd0:    w_wt = r_d - r_u - r_v;
            2'd1:    w_wt = r_u;
            default: w_wt = r_v;
        endcase
        if (r_state == S_SQMUL) begin
            w_ma = $signed(r_m[r_c]);
            w_mb = 36'($signed(r_m[r_c]));
        end else begin
            w_ma = 17'($signed(w_nval));
            w_mb = $signed({2'b00, w_wt});
        end
    end
    assign w_prod = w_ma * w_mb;

    // divider operand selection
    logic [52:0] w_acc_abs;
    logic [16:0] w_m_abs;
    assign w_acc_abs = r_acc[52] ? 53'(-r_acc) : 53'(r_acc);
    assign w_m_abs   = r_m[r_c][16] ? (17'd0 - r_m[r_c]) : r_m[r_c];
    always_comb begin
        case (r_state)
            S_U_START: begin
                w_div_num = {24'd0, r_tx, 16'd0};
                w_div_den = {22'd0, w_weff};
            end
            S_V_START: begin
                w_div_num = {24'd0, r_ty, 16'd0};
                w_div_den = {22'd0, w_heff};
            end
            S_MDIV_START: begin
                w_div_num = w_acc_abs[51:0] + {19'd0, r_d[33:1]};
                w_div_den = {1'b0, r_d};
            end
            default: begin
                w_div_num = {6'd0, w_m_abs, 29'd0} + {22'd0, r_len[30:1]};
                w_div_den = {4'd0, r_len};
            end
        endcase
    end
    assign w_div_start = (r_state == S_U_START && {1'b0, r_tx} < w_weff)
                      || (r_state == S_V_START && {1'b0, r_ty} < w_heff)
                      || (r_state == S_MDIV_START) || (r_state == S_ENC_START);

    uvbnb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // encode and square root helpers
    logic signed [18:0] w_enc;
    logic [15:0]        w_enc_sat;
    logic [61:0]        w_sq_sum;
    assign w_enc = r_m[r_c][16] ? (19'sd32768 - $signed({2'b00, w_div_quo}))
                                : (19'sd32768 + $signed({2'b00, w_div_quo}));
    assign w_enc_sat = w_enc[18] ? 16'd0 : ((w_enc > 19'sd65535) ? 16'hFFFF : w_enc[15:0]);
    assign w_sq_sum  = {1'b0, r_sq_r} + {1'b0, r_sq_bit};

    // table memories: written only on accepted appends, read only while baking
    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == MODE_APPEND && r_tri_count < TRI_CNT_W'(MAX_TRIS)) begin
            r_uv_mem[r_tri_count[TRI_IDX_W-1:0]] <= {i_uv_a, i_uv_b, i_uv_c};
        end
        if (w_issue) begin
            r_uv_rd <= r_uv_mem[r_wi[TRI_IDX_W-1:0]];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == MODE_APPEND && r_tri_count < TRI_CNT_W'(MAX_TRIS)) begin
            r_nm_mem[r_tri_count[TRI_IDX_W-1:0]] <= {i_norm_a, i_norm_b, i_norm_c};
        end
        if (r_state == S_NREAD) begin
            r_nm_rd <= r_nm_mem[r_hit_idx];
        end
    end

    // walk datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_i1 <= r_wi[TRI_IDX_W-1:0];
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_x0 <= w_x0; r_y0 <= w_y0; r_x1 <= w_x1;
        r_y1 <= w_y1; r_x2 <= w_x2; r_y2 <= w_y2;
        r_p0 <= r_x0 * r_y1; r_p1 <= r_y0 * r_x1;
        r_p2 <= r_x2 * r_y1; r_p3 <= r_y2 * r_x1;
        r_p4 <= r_x0 * r_y2; r_p5 <= r_y0 * r_x2;
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tri_count <= '0;
            r_tex_w     <= TEX_SIZE_RESET;
            r_tex_h     <= TEX_SIZE_RESET;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_wi        <= '0;
            r_c         <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TEX_WIDTH) r_tex_w <= i_cfg_data;
                if (i_cfg_idx == CFG_TEX_HEIGHT) r_tex_h <= i_cfg_data;
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1 && (r_state == S_WALK);
            r_v3 <= r_v2 && (r_state == S_WALK);
            if (w_issue) r_wi <= r_wi + 1'b1;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_status <= 1'b0;
                        r_res_hit    <= 1'b0;
                        r_col[0]     <= '0;
                        r_col[1]     <= '0;
                        r_col[2]     <= '0;
                        r_tx         <= i_texel_x;
                        r_ty         <= i_texel_y;
                        r_state      <= S_RESULT;
                        case (i_mode)
                            MODE_CLEAR: r_tri_count <= '0;
                            MODE_APPEND: begin
                                if (r_tri_count < TRI_CNT_W'(MAX_TRIS)) begin
                                    r_tri_count <= r_tri_count + 1'b1;
                                end else begin
                                    r_res_status <= 1'b1;
                                end
                            end
                            MODE_BAKE: r_state <= S_U_START;
                            default: ;
                        endcase
                    end
                end
                S_U_START: begin
                    // texel past the texture edge saturates
                    if (!w_div_start) begin
                        r_pu    <= 16'hFFFF;
                        r_state <= S_V_START;
                    end else begin
                        r_state <= S_U_WAIT;
                    end
                end
                S_U_WAIT: begin
                    if (w_div_done) begin
                        r_pu    <= w_div_quo[15:0];
                        r_state <= S_V_START;
                    end
                end
                S_V_START: begin
                    if (!w_div_start) begin
                        r_pv    <= 16'hFFFF;
                        r_wi    <= '0;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_V_WAIT;
                    end
                end
                S_V_WAIT: begin
                    if (w_div_done) begin
                        r_pv    <= w_div_quo[15:0];
                        r_wi    <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // oldest entry sits in stage 3, so the first pass wins
                    if (r_v3 && w_pass) begin
                        r_d       <= w_dn[33:0];
                        r_u       <= w_un[33:0];
                        r_v       <= w_vn[33:0];
                        r_hit_idx <= r_i3;
                        r_state   <= S_NREAD;
                    end else if (!w_issue && !r_v1 && !r_v2 && !r_v3) begin
                        r_col[0] <= DEF_RED;
                        r_col[1] <= DEF_GREEN;
                        r_col[2] <= DEF_BLUE;
                        r_state  <= S_RESULT;
                    end
                end
                S_NREAD: begin
                    r_c     <= '0;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= r_acc + r_prod;
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_MDIV_START;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MDIV_START: r_state <= S_MDIV_WAIT;
                S_MDIV_WAIT: begin
                    if (w_div_done) begin
                        r_m[r_c] <= r_acc[52] ? (17'd0 - w_div_quo) : w_div_quo;
                        r_acc    <= '0;
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_s     <= '0;
                            r_state <= S_SQMUL;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_SQMUL: r_state <= S_SQACC;
                S_SQACC: begin
                    r_s <= r_s + r_prod[31:0];
                    if (r_c == 2'd2) begin
                        r_c     <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_SQMUL;
                    end
                end
                S_CHECK: begin
                    r_res_hit <= 1'b1;
                    if (r_s <= NEAR_ZERO_SQ) begin
                        r_col[0] <= DEF_RED;
                        r_col[1] <= DEF_GREEN;
                        r_col[2] <= DEF_BLUE;
                        r_state  <= S_RESULT;
                    end else begin
                        r_sq_n   <= {1'b0, r_s, 28'd0};
                        r_sq_r   <= '0;
                        r_sq_bit <= {1'b1, 60'd0};
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_len   <= r_sq_r[30:0];
                        r_state <= S_ENC_START;
                    end else begin
                        if ({1'b0, r_sq_n} >= w_sq_sum) begin
                            r_sq_n <= r_sq_n - w_sq_sum[60:0];
                            r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                        end else begin
                            r_sq_r <= r_sq_r >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_ENC_START: r_state <= S_ENC_WAIT;
                S_ENC_WAIT: begin
                    if (w_div_done) begin
                        r_col[r_c] <= w_enc_sat;
                        if (r_c == 2'd2) begin
                            r_c     <= '0;
                            r_state <= S_RESULT;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_ENC_START;
                        end
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_hit    <= r_res_hit;
                        r_out_red    <= r_col[0];
                        r_out_green  <= r_col[1];
                        r_out_blue   <= r_col[2];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_hit    = r_out_hit;
    assign o_red    = r_out_red;
    assign o_green  = r_out_green;
    assign o_blue   = r_out_blue;

    `UVBNB_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_tri_count <= TRI_CNT_W'(MAX_TRIS))
    `UVBNB_ASSERT_IMP(a_drop_no_hit, i_clk, i_rst_n, o_valid && o_status, !o_hit)
    `UVBNB_ASSERT_NXT(a_append_grows, i_clk, i_rst_n, w_accept && i_mode == MODE_APPEND && r_tri_count < TRI_CNT_W'(MAX_TRIS), r_tri_count == $past(r_tri_count) + 1'b1)
    `UVBNB_ASSERT_IMP(a_div_free, i_clk, i_rst_n, w_div_start, !w_div_busy)
endmodule
`default_nettype wire

// ----- sim/uv_barycentric_normal_baker_core_tb.sv -----
// self-checking testbench for the uv barycentric normal baker core
`timescale 1ns / 1ps
`default_nettype none
module uv_barycentric_normal_baker_core_tb;
    import uvbnb_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        bit [1:0]  mode;
        bit [31:0] uv [3];
        bit [47:0] nrm [3];
        bit [11:0] tx;
        bit [11:0] ty;
    } bake_request_t;

    typedef struct packed {
        bit        status;
        bit        hit;
        bit [15:0] red;
        bit [15:0] green;
        bit [15:0] blue;
    } texel_result_t;

    // keeps a copy of the triangle table and predicts each result
    class baker_scoreboard;
        bit [31:0]      uv_tab [3*MAX_TRIS];
        bit [47:0]      nrm_tab [3*MAX_TRIS];
        int unsigned    tri_total;
        bit [12:0]      tex_w;
        bit [12:0]      tex_h;
        texel_result_t  pending [$];
        int             mismatches;
        int             checked;

        function new();
            tri_total  = 0;
            tex_w      = TEX_SIZE_RESET;
            tex_h      = TEX_SIZE_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function longint round_div(longint num, longint den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint texel_to_uv(bit [11:0] t, bit [12:0] size);
            longint dd;
            longint q;
            dd = (size == 0) ? 1 : size;
            q = (longint'(t) << 16) / dd;
            return (q > 65535) ? 65535 : q;
        endfunction

        function bit [15:0] encode_channel(longint m, longint len);
            longint q;
            q = 32768 + round_div(m <<< 29, len);
            if (q < 0) q = 0;
            if (q > 65535) q = 65535;
            return q[15:0];
        endfunction

        function texel_result_t predict(bake_request_t rq);
            texel_result_t r;
            longint pu, pv, au, av, x0, y0, x1, y1, x2, y2, d, u, v, sum, s, len;
            longint m [3];
            bit found;
            int sh;
            r = '0;
            found = 0;
            case (rq.mode)
                MODE_CLEAR: tri_total = 0;
                MODE_APPEND: begin
                    if (tri_total >= MAX_TRIS) begin
                        r.status = 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            uv_tab[3*tri_total+i]  = rq.uv[i];
                            nrm_tab[3*tri_total+i] = rq.nrm[i];
                        end
                        tri_total++;
                    end
                end
                MODE_BAKE: begin
                    r.red = DEF_RED;
                    r.green = DEF_GREEN;
                    r.blue = DEF_BLUE;
                    pu = texel_to_uv(rq.tx, tex_w);
                    pv = texel_to_uv(rq.ty, tex_h);
                    for (int i = 0; i < tri_total && !found; i++) begin
                        au = longint'(uv_tab[3*i][31:16]);
                        av = longint'(uv_tab[3*i][15:0]);
                        x0 = longint'(uv_tab[3*i+1][31:16]) - au;
                        y0 = longint'(uv_tab[3*i+1][15:0]) - av;
                        x1 = longint'(uv_tab[3*i+2][31:16]) - au;
                        y1 = longint'(uv_tab[3*i+2][15:0]) - av;
                        x2 = pu - au;
                        y2 = pv - av;
                        d = x0 * y1 - y0 * x1;
                        u = x2 * y1 - y2 * x1;
                        v = x0 * y2 - y0 * x2;
                        if (d != 0) begin
                            if (d < 0) begin
                                d = -d;
                                u = -u;
                                v = -v;
                            end
                            if (u >= 0 && v >= 0 && u + v <= d) begin
                                for (int c = 0; c < 3; c++) begin
                                    sh = 32 - 16 * c;
                                    sum = longint'($signed(nrm_tab[3*i][sh +: 16])) * (d - u - v)
                                        + longint'($signed(nrm_tab[3*i+1][sh +: 16])) * u
                                        + longint'($signed(nrm_tab[3*i+2][sh +: 16])) * v;
                                    m[c] = round_div(sum, d);
                                end
                                found = 1;
                            end
                        end
                    end
                    if (found) begin
                        r.hit = 1'b1;
                        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                        if (s > longint'(NEAR_ZERO_SQ)) begin
                            len = longint'(int_sqrt(longint'(s) << 28));
                            r.red   = encode_channel(m[0], len);
                            r.green = encode_channel(m[1], len);
                            r.blue  = encode_channel(m[2], len);
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(bake_request_t rq);
            pending.push_back(predict(rq));
        endfunction

        function void check_result(texel_result_t got);
            texel_result_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p with no request pending", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [1:0]  i_mode = '0;
    logic [31:0] i_uv_a = '0, i_uv_b = '0, i_uv_c = '0;
    logic [47:0] i_norm_a = '0, i_norm_b = '0, i_norm_c = '0;
    logic [11:0] i_texel_x = '0, i_texel_y = '0;
    wire         o_ready, o_valid, o_status, o_hit;
    wire  [15:0] o_red, o_green, o_blue;

    baker_scoreboard sb;
    bit              quiet = 1'b0;
    int              cycles = 0;

    uv_barycentric_normal_baker_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode),
        .i_uv_a(i_uv_a), .i_uv_b(i_uv_b), .i_uv_c(i_uv_c),
        .i_norm_a(i_norm_a), .i_norm_b(i_norm_b), .i_norm_c(i_norm_c),
        .i_texel_x(i_texel_x), .i_texel_y(i_texel_y),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status), .o_hit(o_hit),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("uv_barycentric_normal_baker_core regression: fail");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls plus one long hold-off to back the block up
    initial begin
        int stall_left;
        int hold_left;
        bit held;
        stall_left = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result({o_status, o_hit, o_red, o_green, o_blue});
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!held && sb != null && sb.checked >= 300) begin
                held = 1;
                hold_left = 2500;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_ready <= (stall_left == 0);
            end
        end
    end

    task automatic send_request(bake_request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= rq.mode;
        i_uv_a    <= rq.uv[0];
        i_uv_b    <= rq.uv[1];
        i_uv_c    <= rq.uv[2];
        i_norm_a  <= rq.nrm[0];
        i_norm_b  <= rq.nrm[1];
        i_norm_c  <= rq.nrm[2];
        i_texel_x <= rq.tx;
        i_texel_y <= rq.ty;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(rq);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(bit idx, bit [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_TEX_WIDTH) sb.tex_w = val;
        else sb.tex_h = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bit [47:0] pack_normal(int x, int y, int z);
        return {16'(x), 16'(y), 16'(z)};
    endfunction

    function automatic bit [47:0] rand_normal();
        case ($urandom_range(0, 3))
            0: return 48'({$urandom, $urandom});
            1: return pack_normal($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                                  $urandom_range(0, 20) - 10);
            2: return pack_normal($urandom_range(0, 32768) - 16384,
                                  $urandom_range(0, 32768) - 16384,
                                  $urandom_range(0, 32768) - 16384);
            default: return pack_normal(0, 0, 16384);
        endcase
    endfunction

    function automatic bake_request_t make_op(bit [1:0] mode);
        bake_request_t rq;
        rq.mode = mode;
        for (int i = 0; i < 3; i++) begin
            rq.uv[i]  = $urandom;
            rq.nrm[i] = 48'({$urandom, $urandom});
        end
        rq.tx = $urandom;
        rq.ty = $urandom;
        return rq;
    endfunction

    function automatic bake_request_t make_append();
        bake_request_t rq;
        int k;
        rq = make_op(MODE_APPEND);
        for (int i = 0; i < 3; i++) rq.nrm[i] = rand_normal();
        k = $urandom_range(0, 9);
        if (k == 0) begin
            rq.uv[1] = rq.uv[0];  // degenerate
        end else if (k < 3) begin
            // large triangle over most of the texture
            rq.uv[0] = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))};
            rq.uv[1] = {16'($urandom_range(65200, 65535)), 16'($urandom_range(0, 300))};
            rq.uv[2] = {16'($urandom_range(0, 300)), 16'($urandom_range(65200, 65535))};
            if (k == 2) rq.uv[0] = {16'hffff, 16'hffff};
        end
        return rq;
    endfunction

    function automatic bake_request_t make_bake();
        bake_request_t rq;
        int wmax, hmax;
        rq = make_op(MODE_BAKE);
        wmax = (sb.tex_w == 0 || sb.tex_w > 4094) ? 4095 : sb.tex_w + 1;
        hmax = (sb.tex_h == 0 || sb.tex_h > 4094) ? 4095 : sb.tex_h + 1;
        if ($urandom_range(0, 9) != 0) begin
            rq.tx = $urandom_range(0, wmax);
            rq.ty = $urandom_range(0, hmax);
        end
        return rq;
    endfunction

    task automatic directed_part();
        bake_request_t rq;
        send_request(make_op(MODE_BAKE));       // empty table
        send_request(make_op(2'd3));            // unused mode
        send_request(make_op(MODE_CLEAR));
        rq = make_op(MODE_APPEND);              // collinear vertices
        rq.uv[0] = 32'h0000_0000;
        rq.uv[1] = {16'd100, 16'd100};
        rq.uv[2] = {16'd200, 16'd200};
        send_request(rq);
        rq.uv[1] = {16'h8000, 16'h0000};        // tiny normals, near-zero length
        rq.uv[2] = {16'h0000, 16'h8000};
        for (int i = 0; i < 3; i++) rq.nrm[i] = pack_normal(5, 5, 5);
        send_request(rq);
        rq = make_op(MODE_BAKE);
        rq.tx = 1;
        rq.ty = 1;
        send_request(rq);
        rq = make_op(MODE_APPEND);              // extreme coordinates and normals
        rq.uv[0] = 32'hffff_ffff;
        rq.uv[1] = {16'h0000, 16'hffff};
        rq.uv[2] = {16'hffff, 16'h0000};
        rq.nrm[0] = {16'h7fff, 16'h8000, 16'h7fff};
        rq.nrm[1] = {16'h8000, 16'h8000, 16'h8000};
        rq.nrm[2] = 48'hffff_ffff_ffff;
        send_request(rq);
        rq = make_op(MODE_APPEND);              // opposite normals cancel
        rq.uv[0] = 32'h0000_0000;
        rq.uv[1] = {16'hffff, 16'h0000};
        rq.uv[2] = {16'h0000, 16'hffff};
        rq.nrm[0] = pack_normal(0, 0, 16384);
        rq.nrm[1] = pack_normal(0, 0, -16384);
        rq.nrm[2] = pack_normal(16384, 0, 0);
        send_request(rq);
        rq = make_op(MODE_BAKE);
        foreach (rq.uv[i]) ;
        rq.tx = 255; rq.ty = 255; send_request(rq);
        rq.tx = 4095; rq.ty = 4095; send_request(rq);
        rq.tx = 0; rq.ty = 255; send_request(rq);
        rq.tx = 255; rq.ty = 0; send_request(rq);
        rq.tx = 128; rq.ty = 0; send_request(rq);
        rq.tx = 0; rq.ty = 0; send_request(rq);
        send_request(make_op(MODE_CLEAR));
        send_request(make_op(MODE_BAKE));
        drain();
    endtask

    // full table, dropped appends, then a few bakes over the whole table
    task automatic fill_table();
        send_request(make_op(MODE_CLEAR));
        for (int i = 0; i < MAX_TRIS + 3; i++) send_request(make_append());
        for (int i = 0; i < 10; i++) send_request(make_bake());
        send_request(make_op(MODE_CLEAR));
        drain();
    endtask

    task automatic random_phase(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4) send_request(make_op(2'd3));
            else if (r < 12 || (sb.tri_total >= 12 && r < 35)) send_request(make_op(MODE_CLEAR));
            else if (r < 45) send_request(make_append());
            else send_request(make_bake());
            if ($urandom_range(0, 99) == 0) drain();
        end
        drain();
    endtask

    initial begin
        bit [12:0] widths [8];
        bit [12:0] heights [8];
        sb = new();
        widths  = '{13'd256, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd0, 13'd0};
        heights = '{13'd256, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480, 13'd0, 13'd0};
        widths[6]  = $urandom_range(1, 4096);
        heights[6] = $urandom_range(1, 4096);
        widths[7]  = $urandom_range(1, 64);
        heights[7] = $urandom_range(1, 64);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_part();
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_TEX_WIDTH, widths[p]);
            write_reg(CFG_TEX_HEIGHT, heights[p]);
            quiet = (p == 2);
            random_phase(200);
            if (p == 0) fill_table();
        end
        quiet = 1'b0;
        drain();
        repeat (600) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("uv_barycentric_normal_baker_core regression: pass");
        else
            $display("uv_barycentric_normal_baker_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/uvbnb_pkg.sv
hdl/uvbnb_div.sv
hdl/uv_barycentric_normal_baker_core.sv
sim/uv_barycentric_normal_baker_core_tb.sv
